// ===== src/jsig_pkg.sv =====
// Shared types and constants for the job-shop instance generator.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package jsig_pkg;

  // minimal-standard generator: modulus 2^31-1 and multiplier
  localparam logic [30:0] LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [14:0] LCG_MUL    = 15'd16807;
  // processing times are drawn from 1..TIME_RANGE
  localparam logic [14:0] TIME_RANGE = 15'd99;

  // field widths of the channels
  localparam int unsigned SEED_W  = 31;
  localparam int unsigned MCNT_W  = 6;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned MACH_W  = 5;
  localparam int unsigned PROC_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MCNT_W-1:0] MCNT_RESET = 6'd15;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_SEED     = 2'd0,
    CFG_ORDER_SEED    = 2'd1,
    CFG_MACHINE_COUNT = 2'd2
  } cfg_idx_t;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_T_MUL  = 12'b0000_0000_0010,
    ST_T_MOD  = 12'b0000_0000_0100,
    ST_T_SMUL = 12'b0000_0000_1000,
    ST_T_SCL  = 12'b0000_0001_0000,
    ST_O_MOD  = 12'b0000_0010_0000,
    ST_O_SMUL = 12'b0000_0100_0000,
    ST_O_SCL  = 12'b0000_1000_0000,
    ST_RD_O   = 12'b0001_0000_0000,
    ST_WR_I   = 12'b0010_0000_0000,
    ST_WR_O   = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_t;

  // request to the shared multiply / reduce unit
  typedef struct packed {
    logic              load;
    logic [30:0]       a;
    logic [14:0]       b;
  } mul_req_t;

  // reduced views of the registered product
  typedef struct packed {
    logic [30:0]       rem;   // product mod 2^31-1
    logic [15:0]       quot;  // floor(product / (2^31-1))
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== src/jsig_if.sv =====
// Valid/ready channel interfaces: job request, operation result, register write.
// Depends on jsig_pkg for the field widths.
`default_nettype none

interface jsig_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface jsig_out_if;
  logic                          valid;
  logic                          ready;
  logic [jsig_pkg::POS_W-1:0]    position;
  logic [jsig_pkg::MACH_W-1:0]   machine;
  logic [jsig_pkg::PROC_W-1:0]   processing;
  logic                          last;
  modport source (output valid, output position, output machine, output processing,
                  output last, input ready);
  modport sink   (input valid, input position, input machine, input processing,
                  input last, output ready);
endinterface

interface jsig_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [jsig_pkg::CFG_IDX_W-1:0]  index;
  logic [jsig_pkg::SEED_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/jsig_mulmod.sv =====
// Shared 31x15 multiplier with a registered product and Mersenne-modulus reduction.
// Depends on jsig_pkg for the request and response structs.
`default_nettype none

module jsig_mulmod (
  input  wire logic               clk,
  input  wire jsig_pkg::mul_req_t req,
  output jsig_pkg::mul_rsp_t      rsp
);

  logic [45:0] prod_nxt;
  logic [45:0] prod_r;
  logic [14:0] hi;
  logic [30:0] lo;
  logic [31:0] sum;
  logic        wrap;

  // multiply stage
  assign prod_nxt = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_r <= prod_nxt;
    end
  end

  // p = hi*2^31 + lo = hi*M + (hi + lo), so one add and one compare settle both
  assign hi   = prod_r[45:31];
  assign lo   = prod_r[30:0];
  assign sum  = {1'b0, lo} + {17'b0, hi};
  assign wrap = (sum >= {1'b0, jsig_pkg::LCG_MOD});

  always_comb begin
    rsp.rem  = wrap ? 31'(sum - {1'b0, jsig_pkg::LCG_MOD}) : sum[30:0];
    rsp.quot = {1'b0, hi} + {15'b0, wrap};
  end

endmodule

`default_nettype wire

// ===== src/job_shop_instance_generator.sv =====
// Job-shop instance generator: one job of operations per request transaction.
// Top level; depends on jsig_pkg, jsig_if.sv and jsig_mulmod.
//
// Channels: in_ch carries one job request (restart reloads both generators
// from the seed registers first). out_ch returns one transaction per operation,
// in position order, with last set on the final one. cfg_ch writes proc_seed,
// order_seed and machine_count by index; it is always ready and is meant to be
// written while no job is in progress.
// Sequence: a request is taken in the idle state, then each operation steps
// through T_MUL, T_MOD, T_SMUL, T_SCL, O_MOD, O_SMUL, O_SCL, RD_O, WR_I, WR_O
// and OUT, with the result shown in OUT. The sequence is shaped by the one
// shared 31x15 multiplier (two generator steps and two scalings per operation)
// and by the single read and single write port of the machine-order memory.
// A machine count of zero ends the job in the accept cycle with no result.
// in_ch.ready is high only between jobs. A stalled receiver holds the sequencer
// in its output state with the result stable until it is taken.
// Reset: seeds go to 1, machine count to 15, both generators to 0.

`default_nettype none

module job_shop_instance_generator #(
  parameter int MAX_MACHINES = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  jsig_in_if.sink      in_ch,
  jsig_out_if.source   out_ch,
  jsig_cfg_if.sink     cfg_ch
);

  localparam int IDXW = $clog2(MAX_MACHINES);
  localparam int CNTW = $clog2(MAX_MACHINES + 1);

  jsig_pkg::state_t state_r, state_nxt;

  logic [jsig_pkg::SEED_W-1:0] proc_seed_r, order_seed_r;
  logic [jsig_pkg::MCNT_W-1:0] mcount_r;
  logic [30:0]                 tg_r, og_r;
  logic [CNTW-1:0]             mjob_r;
  logic [IDXW-1:0]             pos_r;
  logic [IDXW-1:0]             other_r;
  logic [IDXW-1:0]             vi_r;
  logic [jsig_pkg::PROC_W-1:0] proc_r;

  logic [jsig_pkg::POS_W-1:0]  out_pos_r;
  logic [jsig_pkg::MACH_W-1:0] out_mach_r;
  logic [jsig_pkg::PROC_W-1:0] out_proc_r;
  logic                        out_last_r;

  logic [CNTW-1:0]             m_sat;
  logic [CNTW-1:0]             span;
  logic                        last_op;
  logic                        in_acc;
  logic                        out_acc;

  jsig_pkg::mul_req_t          mreq;
  jsig_pkg::mul_rsp_t          mrsp;

  // machine order memory with per-entry valid bits (invalid reads as identity)
  logic [IDXW-1:0]             ord_mem [MAX_MACHINES];
  logic [MAX_MACHINES-1:0]     vld_r;
  logic                        rd_en, wr_en;
  logic [IDXW-1:0]             rd_addr, wr_addr, wr_data;
  logic [IDXW-1:0]             rd_data_r, rd_addr_r;
  logic                        rd_hit_r;
  logic [IDXW-1:0]             rd_val;
  logic [31:0]                 mach_ext;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // handshakes and result payload
  assign in_ch.ready       = (state_r == jsig_pkg::ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = (state_r == jsig_pkg::ST_OUT);
  assign out_ch.position   = out_pos_r;
  assign out_ch.machine    = out_mach_r;
  assign out_ch.processing = out_proc_r;
  assign out_ch.last       = out_last_r;

  // machine count saturated to the memory depth
  always_comb begin
    if (32'(mcount_r) > 32'(MAX_MACHINES)) begin
      m_sat = CNTW'(MAX_MACHINES);
    end else begin
      m_sat = CNTW'(mcount_r);
    end
  end

  assign span    = mjob_r - CNTW'(pos_r);
  assign last_op = ((CNTW'(pos_r) + CNTW'(1)) == mjob_r);

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_seed_r  <= jsig_pkg::SEED_RESET;
      order_seed_r <= jsig_pkg::SEED_RESET;
      mcount_r     <= jsig_pkg::MCNT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        jsig_pkg::CFG_PROC_SEED:     proc_seed_r  <= cfg_ch.data;
        jsig_pkg::CFG_ORDER_SEED:    order_seed_r <= cfg_ch.data;
        jsig_pkg::CFG_MACHINE_COUNT: mcount_r     <= cfg_ch.data[jsig_pkg::MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier request per sequencer step
  always_comb begin
    mreq.load = 1'b0;
    mreq.a    = tg_r;
    mreq.b    = jsig_pkg::LCG_MUL;
    unique case (state_r)
      jsig_pkg::ST_T_MUL: begin
        mreq.load = 1'b1;
      end
      jsig_pkg::ST_T_SMUL: begin
        mreq.load = 1'b1;
        mreq.b    = jsig_pkg::TIME_RANGE;
      end
      jsig_pkg::ST_T_SCL: begin
        mreq.load = 1'b1;
        mreq.a    = og_r;
      end
      jsig_pkg::ST_O_SMUL: begin
        mreq.load = 1'b1;
        mreq.a    = og_r;
        mreq.b    = 15'(span);
      end
      default: ;
    endcase
  end

  jsig_mulmod u_mulmod (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  // memory port control for the swap
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_r;
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = rd_val;
    unique case (state_r)
      jsig_pkg::ST_O_MOD: begin
        rd_en = 1'b1;
      end
      jsig_pkg::ST_RD_O: begin
        rd_en   = 1'b1;
        rd_addr = other_r;
      end
      jsig_pkg::ST_WR_I: begin
        wr_en = 1'b1;
      end
      jsig_pkg::ST_WR_O: begin
        wr_en   = 1'b1;
        wr_addr = other_r;
        wr_data = vi_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ord_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ord_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // valid bits: cleared at the start of every job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (in_acc) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_val   = rd_hit_r ? rd_data_r : rd_addr_r;
  assign mach_ext = 32'(rd_val);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jsig_pkg::ST_IDLE: begin
        if (in_acc && (m_sat != '0)) begin
          state_nxt = jsig_pkg::ST_T_MUL;
        end
      end
      jsig_pkg::ST_T_MUL:  state_nxt = jsig_pkg::ST_T_MOD;
      jsig_pkg::ST_T_MOD:  state_nxt = jsig_pkg::ST_T_SMUL;
      jsig_pkg::ST_T_SMUL: state_nxt = jsig_pkg::ST_T_SCL;
      jsig_pkg::ST_T_SCL:  state_nxt = jsig_pkg::ST_O_MOD;
      jsig_pkg::ST_O_MOD:  state_nxt = jsig_pkg::ST_O_SMUL;
      jsig_pkg::ST_O_SMUL: state_nxt = jsig_pkg::ST_O_SCL;
      jsig_pkg::ST_O_SCL:  state_nxt = jsig_pkg::ST_RD_O;
      jsig_pkg::ST_RD_O:   state_nxt = jsig_pkg::ST_WR_I;
      jsig_pkg::ST_WR_I:   state_nxt = jsig_pkg::ST_WR_O;
      jsig_pkg::ST_WR_O:   state_nxt = jsig_pkg::ST_OUT;
      jsig_pkg::ST_OUT: begin
        if (out_acc) begin
          state_nxt = out_last_r ? jsig_pkg::ST_IDLE : jsig_pkg::ST_T_MUL;
        end
      end
      default: state_nxt = jsig_pkg::ST_IDLE;
    endcase
  end

  // sequencer state and generator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsig_pkg::ST_IDLE;
      tg_r    <= '0;
      og_r    <= '0;
      mjob_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_ch.restart) begin
          tg_r <= proc_seed_r;
          og_r <= order_seed_r;
        end
        mjob_r <= m_sat;
        pos_r  <= '0;
      end
      if (state_r == jsig_pkg::ST_T_MOD) begin
        tg_r <= mrsp.rem;
      end
      if (state_r == jsig_pkg::ST_O_MOD) begin
        og_r <= mrsp.rem;
      end
      if (out_acc && !out_last_r) begin
        pos_r <= pos_r + IDXW'(1);
      end
    end
  end

  // per-operation payload
  always_ff @(posedge clk) begin
    if (state_r == jsig_pkg::ST_T_SCL) begin
      proc_r <= jsig_pkg::PROC_W'(mrsp.quot) + jsig_pkg::PROC_W'(1);
    end
    if (state_r == jsig_pkg::ST_O_SMUL) begin
      vi_r <= rd_val;
    end
    if (state_r == jsig_pkg::ST_O_SCL) begin
      other_r <= pos_r + IDXW'(mrsp.quot);
    end
    if (state_r == jsig_pkg::ST_WR_I) begin
      out_pos_r  <= jsig_pkg::POS_W'(pos_r);
      out_mach_r <= mach_ext[jsig_pkg::MACH_W-1:0];
      out_proc_r <= proc_r;
      out_last_r <= last_op;
    end
  end

  // checks on the sequencer and arithmetic
  a_proc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.processing != '0) &&
                     ({8'b0, out_ch.processing} <= jsig_pkg::TIME_RANGE))
    else $error("processing time out of range");

  a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jsig_pkg::ST_RD_O) |-> (other_r >= pos_r) && (CNTW'(other_r) < mjob_r))
    else $error("swap index outside the unshuffled part");

  a_job_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> in_ch.ready)
    else $error("job did not end after its last operation");

  a_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (m_sat == '0)) |=> (in_ch.ready && !out_ch.valid))
    else $error("empty job did not return to idle");

endmodule

`default_nettype wire

// ===== sim/job_shop_instance_generator_tb.sv =====
// Self-checking testbench for the job-shop instance generator: job requests in,
// one operation transaction per position out, checked against an in-bench predictor.
// Depends on jsig_pkg, the channel interfaces in jsig_if.sv and the top level.
`default_nettype none

module job_shop_instance_generator_tb;

  localparam int MAX_MACHINES  = 32;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 40;
  localparam int PHASE_JOBS    = 10;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int REPORT_LIMIT  = 10;
  // index that selects no register
  localparam logic [jsig_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // one expected operation of a job
  typedef struct packed {
    logic [jsig_pkg::POS_W-1:0]  position;
    logic [jsig_pkg::MACH_W-1:0] machine;
    logic [jsig_pkg::PROC_W-1:0] processing;
    logic                        last;
  } op_t;

  logic clk = 1'b0;
  logic rst_n;

  jsig_in_if  in_if ();
  jsig_out_if out_if ();
  jsig_cfg_if cfg_if ();

  job_shop_instance_generator #(.MAX_MACHINES(MAX_MACHINES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor copy of registers and generators
  logic [jsig_pkg::SEED_W-1:0] proc_seed_r;
  logic [jsig_pkg::SEED_W-1:0] order_seed_r;
  logic [jsig_pkg::MCNT_W-1:0] machine_count_r;
  logic [jsig_pkg::SEED_W-1:0] time_gen;
  logic [jsig_pkg::SEED_W-1:0] order_gen;

  op_t expected_ops[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("job_shop_instance_generator_tb: FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result receiver with random stalls
  always @(posedge clk) begin
    if (hold_req || hold_left != 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // minimal-standard generator step: s * 16807 mod 2^31-1
  function automatic logic [jsig_pkg::SEED_W-1:0] lcg_step(logic [jsig_pkg::SEED_W-1:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(jsig_pkg::LCG_MUL);
    return jsig_pkg::SEED_W'(prod % 64'(jsig_pkg::LCG_MOD));
  endfunction

  // floor(s * span / (2^31-1))
  function automatic int unsigned scale_down(logic [jsig_pkg::SEED_W-1:0] s,
                                             int unsigned span);
    logic [63:0] prod;
    prod = 64'(s) * 64'(span);
    return 32'(prod / 64'(jsig_pkg::LCG_MOD));
  endfunction

  // expected operations of one job
  task automatic predict_job(bit restart);
    logic [jsig_pkg::MACH_W-1:0] order_tbl [MAX_MACHINES];
    logic [jsig_pkg::MACH_W-1:0] tmp;
    int unsigned m;
    int unsigned other;
    int unsigned i;
    op_t op;
    if (restart) begin
      time_gen  = proc_seed_r;
      order_gen = order_seed_r;
    end
    m = 32'(machine_count_r);
    if (m > MAX_MACHINES) m = MAX_MACHINES;
    for (i = 0; i < MAX_MACHINES; i++) order_tbl[i] = jsig_pkg::MACH_W'(i);
    // forward swap of the machine order, one draw per position
    for (i = 0; i < m; i++) begin
      time_gen = lcg_step(time_gen);
      op.processing = jsig_pkg::PROC_W'(1 + scale_down(time_gen, 32'(jsig_pkg::TIME_RANGE)));
      order_gen = lcg_step(order_gen);
      other = i + scale_down(order_gen, m - i);
      if (other >= m) other = m - 1;
      tmp = order_tbl[i];
      order_tbl[i] = order_tbl[other];
      order_tbl[other] = tmp;
      op.position = jsig_pkg::POS_W'(i);
      op.machine  = order_tbl[i];
      op.last     = (i + 1 == m);
      expected_ops = {expected_ops, op};
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_ops
    op_t got;
    op_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.position, out_if.machine, out_if.processing, out_if.last};
      if (expected_ops.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected operation: pos=%0d mach=%0d proc=%0d last=%0d",
                   got.position, got.machine, got.processing, got.last);
      end else begin
        want = expected_ops.pop_front();
        if (got.position !== want.position || got.machine !== want.machine ||
            got.processing !== want.processing || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("operation mismatch: expected pos=%0d mach=%0d proc=%0d last=%0d, %s",
                     want.position, want.machine, want.processing, want.last,
                     $sformatf("actual pos=%0d mach=%0d proc=%0d last=%0d",
                               got.position, got.machine, got.processing, got.last));
        end
      end
    end
  end

  // one job request transaction
  task automatic send_job(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'($urandom);
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_job(restart);
  endtask

  // called in the step of the last accepted request
  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  // one register write transaction
  task automatic write_reg(logic [jsig_pkg::CFG_IDX_W-1:0] idx,
                           logic [jsig_pkg::SEED_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      jsig_pkg::CFG_PROC_SEED:     proc_seed_r = value;
      jsig_pkg::CFG_ORDER_SEED:    order_seed_r = value;
      jsig_pkg::CFG_MACHINE_COUNT: machine_count_r = value[jsig_pkg::MCNT_W-1:0];
      default: ;
    endcase
  endtask

  // wait for all results, then let the block settle
  task automatic wait_idle();
    while (expected_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full register set, written while idle
  task automatic configure(logic [jsig_pkg::SEED_W-1:0] tseed,
                           logic [jsig_pkg::SEED_W-1:0] oseed,
                           logic [jsig_pkg::MCNT_W-1:0] count);
    wait_idle();
    write_reg(jsig_pkg::CFG_PROC_SEED, tseed);
    write_reg(jsig_pkg::CFG_ORDER_SEED, oseed);
    write_reg(jsig_pkg::CFG_MACHINE_COUNT, {25'($urandom), count});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_traffic(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // seeds: mostly random in range, sometimes the edges
  function automatic logic [jsig_pkg::SEED_W-1:0] pick_seed();
    case ($urandom_range(19))
      0:       return '0;
      1:       return jsig_pkg::LCG_MOD;
      2:       return jsig_pkg::SEED_W'(1);
      3:       return jsig_pkg::SEED_W'(jsig_pkg::LCG_MOD - 31'd1);
      default: return jsig_pkg::SEED_W'($urandom_range(32'h7FFF_FFFE, 1));
    endcase
  endfunction

  // machine counts: mostly small jobs, some larger up to full, a few zero or oversized
  function automatic logic [jsig_pkg::MCNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return jsig_pkg::MCNT_W'($urandom_range(8, 1));
    if (r < 90) return jsig_pkg::MCNT_W'($urandom_range(MAX_MACHINES, 9));
    if (r < 94) return '0;
    return jsig_pkg::MCNT_W'($urandom_range(63, MAX_MACHINES + 1));
  endfunction

  // generators untouched since reset: times of 1, identity order
  task automatic test_reset_state();
    set_traffic(0, 0);
    send_job(1'b0);
    send_job(1'b0);
    stop_sending();
  endtask

  // seeds that collapse to zero, and the range edges
  task automatic test_seed_extremes();
    set_traffic(0, 0);
    configure('0, jsig_pkg::LCG_MOD, jsig_pkg::MCNT_W'(4));
    send_job(1'b1);
    send_job(1'b0);
    stop_sending();
    configure(jsig_pkg::SEED_W'(1), jsig_pkg::SEED_W'(jsig_pkg::LCG_MOD - 31'd1),
              jsig_pkg::MCNT_W'(5));
    send_job(1'b1);
    send_job(1'b0);
    stop_sending();
  endtask

  // zero count still loads on restart, single operation, saturation
  task automatic test_machine_count_edges();
    set_traffic(0, 0);
    configure(pick_seed(), pick_seed(), '0);
    send_job(1'b1);
    send_job(1'b0);
    stop_sending();
    configure(jsig_pkg::SEED_W'($urandom_range(32'h7FFF_FFFE, 1)),
              jsig_pkg::SEED_W'($urandom_range(32'h7FFF_FFFE, 1)), jsig_pkg::MCNT_W'(1));
    send_job(1'b0);
    send_job(1'b1);
    stop_sending();
    configure(proc_seed_r, order_seed_r, jsig_pkg::MCNT_W'(MAX_MACHINES));
    send_job(1'b0);
    stop_sending();
    configure(proc_seed_r, order_seed_r, jsig_pkg::MCNT_W'(MAX_MACHINES + 1));
    send_job(1'b1);
    stop_sending();
    configure(proc_seed_r, order_seed_r, '1);
    send_job(1'b0);
    stop_sending();
  endtask

  // a write to the spare index changes nothing
  task automatic test_unused_index();
    set_traffic(0, 0);
    configure(jsig_pkg::SEED_W'($urandom), jsig_pkg::SEED_W'($urandom),
              jsig_pkg::MCNT_W'(6));
    write_reg(CFG_NO_REG, jsig_pkg::SEED_W'($urandom));
    cfg_if.valid <= 1'b0;
    send_job(1'b1);
    send_job(1'b0);
    stop_sending();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_pressure();
    set_traffic(0, 0);
    configure(pick_seed(), pick_seed(), jsig_pkg::MCNT_W'(MAX_MACHINES));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (4) send_job(1'($urandom));
    stop_sending();
  endtask

  // random phases across all traffic patterns
  task automatic test_random();
    int phase;
    int k;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0:       set_traffic(0, 0);
        1:       set_traffic(59, 0);
        2:       set_traffic(0, 59);
        default: set_traffic(30, 30);
      endcase
      configure(pick_seed(), pick_seed(), pick_count());
      for (k = 0; k < PHASE_JOBS; k++) begin
        if (k == 0) send_job($urandom_range(9) != 0);
        else send_job($urandom_range(9) == 0);
      end
      stop_sending();
    end
  endtask

  // reset values of the predictor and the sequence of tests
  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.restart  <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= jsig_pkg::CFG_PROC_SEED;
    cfg_if.data    <= '0;
    proc_seed_r     = jsig_pkg::SEED_RESET;
    order_seed_r    = jsig_pkg::SEED_RESET;
    machine_count_r = jsig_pkg::MCNT_RESET;
    time_gen        = '0;
    order_gen       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_seed_extremes();
    test_machine_count_edges();
    test_unused_index();
    test_pressure();
    test_random();

    wait_idle();
    if (mismatch_count == 0 && expected_ops.size() == 0) begin
      $display("job_shop_instance_generator_tb: PASS");
    end else begin
      $display("job_shop_instance_generator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
